FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the above.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    `ASSERT_CLK(label, clk, rst_n, (pre) |-> (post), msg)

// Next-cycle implication form.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    `ASSERT_CLK(label, clk, rst_n, (pre) |=> (post), msg)

`endif

FILE: hw/rtl/u16run_pkg.sv
`timescale 1ns / 1ps

package u16run_pkg;

    localparam logic [7:0] PRINT_LO        = 8'h20;
    localparam logic [7:0] PRINT_HI        = 8'h7E;
    localparam logic [7:0] BYTE_ZERO       = 8'h00;
    localparam logic [4:0] COUNT_MAX       = 5'd31;
    localparam logic [3:0] MIN_CHARS_RESET = 4'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } t_in_item;

    typedef struct packed {
        logic [6:0] text_char;
        logic       run_end;
    } t_out_item;

    // Results still owed for the request just taken
    typedef struct packed {
        logic [3:0] flush_n;
        logic       pend;
        logic       term;
        logic [6:0] ch;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FLUSH,
        S_CHAR,
        S_TERM
    } t_state;

endpackage

FILE: hw/rtl/utf16le_printable_run_extractor.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+---------------------------------
// in       | in  | i_in_valid / o_in_stall | i_in_data  (data_byte, is_final)
// out      | out | o_out_valid / i_out_stall| o_out_data (text_char, run_end)
// cfg      | in  | i_cfg_we               | i_cfg_data (min_chars)
//
// A byte giving at most one result is taken every cycle while the output moves;
// a result held by i_out_stall stalls the input until it is taken.
// A qualifying run flushes its n held characters, each read from the hold RAM
// and then presented, then the current character, then the terminator if the
// byte was final, with the input stalled throughout. A final pair with no flush
// that gives a character and a terminator stalls the input while both are presented.
// Synchronous active-low reset, input stalled while held; the hold RAM has no
// clearing pass, only entries written in the current run are ever read back.
module utf16le_printable_run_extractor #(
    parameter int HOLD_DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  u16run_pkg::t_in_item   i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output u16run_pkg::t_out_item  o_out_data,
    input  logic                   i_cfg_we,
    input  logic [3:0]             i_cfg_data
);

    localparam int         IDX_W   = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam logic [6:0] HOLD_W7 = 7'(HOLD_DEPTH);

    u16run_pkg::t_state    r_state, n_state;
    logic                  r_phase, n_phase;
    logic [6:0]            r_pend, n_pend;
    logic [4:0]            r_count, n_count;
    logic [3:0]            r_min;
    u16run_pkg::t_job      r_job, n_job;
    logic [3:0]            r_fl_idx;
    logic                  r_out_valid;
    u16run_pkg::t_out_item r_out;

    logic [6:0]            r_hold_mem [HOLD_DEPTH];
    logic [6:0]            r_rd_data;

    logic                  w_printable;
    logic                  w_zero;
    logic [4:0]            w_cnt_inc;
    logic [4:0]            w_thr;
    logic [6:0]            w_wpos;
    logic [6:0]            w_rpos;
    logic [3:0]            w_nfl;
    logic                  w_we;
    logic                  w_direct;
    u16run_pkg::t_out_item w_direct_item;
    logic                  w_slot_free;
    logic                  w_fl_last;

    logic                  w_accept;
    logic                  w_rd_en;
    logic                  w_load;
    u16run_pkg::t_out_item w_load_item;
    logic                  w_idx_inc;

    // ---------------- per-byte decode ----------------
    always_comb begin
        w_printable = (i_in_data.data_byte >= u16run_pkg::PRINT_LO) &&
                      (i_in_data.data_byte <= u16run_pkg::PRINT_HI);
        w_zero      = (i_in_data.data_byte == u16run_pkg::BYTE_ZERO);
        w_cnt_inc   = (r_count == u16run_pkg::COUNT_MAX) ? r_count : 5'(r_count + 5'd1);
        w_thr       = {1'b0, r_min} + 5'd1;
        w_wpos      = 7'(w_cnt_inc) - 7'd1;
        w_nfl       = ({3'b0, r_min} <= HOLD_W7) ? r_min : HOLD_W7[3:0];

        n_phase     = r_phase;
        n_count     = r_count;
        n_pend      = r_pend;
        w_we        = 1'b0;
        n_job       = '0;
        n_job.ch    = r_pend;

        if (r_phase && w_zero) begin
            n_count       = w_cnt_inc;
            n_phase       = 1'b0;
            w_we          = (w_wpos < HOLD_W7);
            n_job.pend    = (w_cnt_inc >= w_thr);
            n_job.flush_n = (w_cnt_inc == w_thr) ? w_nfl : 4'd0;
            n_job.term    = i_in_data.is_final && (w_cnt_inc > {1'b0, r_min});
        end else if (r_phase) begin
            // non-zero after a candidate: close and restart at this byte
            n_job.term = (r_count > {1'b0, r_min});
            n_count    = '0;
            if (w_printable) begin
                n_pend  = i_in_data.data_byte[6:0];
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
            end
        end else begin
            if (w_printable) begin
                n_pend  = i_in_data.data_byte[6:0];
                n_phase = 1'b1;
            end else begin
                n_count = '0;
            end
            n_job.term = (!w_printable || i_in_data.is_final) &&
                         (r_count > {1'b0, r_min});
        end

        if (i_in_data.is_final) begin
            n_phase = 1'b0;
            n_count = '0;
            n_pend  = '0;
        end

        w_direct                = (n_job.flush_n == 4'd0) && (n_job.pend ^ n_job.term);
        w_direct_item.text_char = n_job.pend ? n_job.ch : 7'd0;
        w_direct_item.run_end   = !n_job.pend;
    end

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_fl_last   = (4'(r_fl_idx + 4'd1) == r_job.flush_n);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            u16run_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (n_job.flush_n != 4'd0) begin
                        n_state = u16run_pkg::S_READ;
                    end else if (n_job.pend && n_job.term) begin
                        n_state = u16run_pkg::S_CHAR;
                    end
                end
            end
            u16run_pkg::S_READ: begin
                n_state = u16run_pkg::S_FLUSH;
            end
            u16run_pkg::S_FLUSH: begin
                if (w_slot_free) begin
                    n_state = w_fl_last ? u16run_pkg::S_CHAR : u16run_pkg::S_READ;
                end
            end
            u16run_pkg::S_CHAR: begin
                if (w_slot_free) begin
                    n_state = r_job.term ? u16run_pkg::S_TERM : u16run_pkg::S_IDLE;
                end
            end
            u16run_pkg::S_TERM: begin
                if (w_slot_free) begin
                    n_state = u16run_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = u16run_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        o_in_stall  = 1'b1;
        w_accept    = 1'b0;
        w_rd_en     = 1'b0;
        w_load      = 1'b0;
        w_load_item = '0;
        w_idx_inc   = 1'b0;
        case (r_state)
            u16run_pkg::S_IDLE: begin
                o_in_stall  = !i_rst_n || !w_slot_free;
                w_accept    = i_rst_n && i_in_valid && w_slot_free;
                w_load      = w_accept && w_direct;
                w_load_item = w_direct_item;
            end
            u16run_pkg::S_READ: begin
                w_rd_en = 1'b1;
            end
            u16run_pkg::S_FLUSH: begin
                w_load                = w_slot_free;
                w_load_item.text_char = r_rd_data;
                w_idx_inc             = w_slot_free;
            end
            u16run_pkg::S_CHAR: begin
                w_load                = w_slot_free;
                w_load_item.text_char = r_job.ch;
            end
            u16run_pkg::S_TERM: begin
                w_load              = w_slot_free;
                w_load_item.run_end = 1'b1;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // ---------------- hold RAM ----------------
    assign w_rpos = {3'b0, r_fl_idx};

    always_ff @(posedge i_clk) begin
        if (w_accept && w_we) begin
            r_hold_mem[w_wpos[IDX_W-1:0]] <= r_pend;
        end
        if (w_rd_en) begin
            r_rd_data <= r_hold_mem[w_rpos[IDX_W-1:0]];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= u16run_pkg::S_IDLE;
            r_phase     <= 1'b0;
            r_pend      <= '0;
            r_count     <= '0;
            r_min       <= u16run_pkg::MIN_CHARS_RESET;
            r_fl_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_min <= i_cfg_data;
            end
            if (w_accept) begin
                r_phase  <= n_phase;
                r_pend   <= n_pend;
                r_count  <= n_count;
                r_fl_idx <= '0;
            end else if (w_idx_inc) begin
                r_fl_idx <= 4'(r_fl_idx + 4'd1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= n_job;
        end
        if (w_load) begin
            r_out <= w_load_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/u16run_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u16run_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input u16run_pkg::t_in_item  i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input u16run_pkg::t_out_item o_out_data,
    input logic                  i_cfg_we,
    input logic [3:0]            i_cfg_data
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "out request dropped while stalled")
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data), "out request changed while stalled")
    `ASSERT_IMPL(a_term_blank, i_clk, i_rst_n, o_out_valid && o_out_data.run_end, o_out_data.text_char == 7'd0, "terminator carries a character")
    `ASSERT_IMPL(a_char_print, i_clk, i_rst_n, o_out_valid && !o_out_data.run_end, (o_out_data.text_char >= 7'h20) && (o_out_data.text_char <= 7'h7E), "non-printable character emitted")

endmodule

bind utf16le_printable_run_extractor u16run_chk u_chk (.*);

FILE: dv/tb_utf16le_printable_run_extractor.sv
`timescale 1ns / 1ps

module tb_utf16le_printable_run_extractor;

    localparam int HOLD_DEPTH  = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 40;
    localparam int N_ROWS      = 22;
    localparam int N_PHASES    = 6;
    localparam int PHASE_BYTES = 48;

    // how a generated run is closed
    typedef enum int {
        END_NONPRINT,
        END_PRINTABLE,
        END_FINAL_PAIR,
        END_LONE,
        END_OPEN
    } t_run_close;

    typedef struct packed {
        logic [7:0]            data_byte;
        logic                  is_final;
        logic                  typed;
        logic [4:0]            n_out;
        u16run_pkg::t_out_item last_out;
    } t_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    u16run_pkg::t_in_item  i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall;
    u16run_pkg::t_out_item o_out_data;
    logic                  i_cfg_we   = 1'b0;
    logic [3:0]            i_cfg_data = u16run_pkg::MIN_CHARS_RESET;

    // scanner state as the block should hold it
    logic [3:0] min_pairs = u16run_pkg::MIN_CHARS_RESET;
    logic       cand_open = 1'b0;
    logic [6:0] cand_char = '0;
    logic [4:0] pair_cnt  = '0;
    logic [6:0] held_chars [HOLD_DEPTH];

    u16run_pkg::t_out_item expected_text [$];
    int         step_results;
    int         mismatches  = 0;
    int         quiet_count = 0;
    bit         calm        = 1'b0;

    // only the two ends of the flush run and the easy closes are spelt out
    t_row directed_rows [N_ROWS] = '{
        '{8'hFF, 1'b0, 1'b1, 5'd0, '{7'h00, 1'b0}},
        '{8'h00, 1'b0, 1'b1, 5'd0, '{7'h00, 1'b0}},
        '{8'h41, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h00, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h20, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h00, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h7E, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h00, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h30, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h00, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h31, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h00, 1'b0, 1'b1, 5'd5, '{7'h31, 1'b0}},
        '{8'h7F, 1'b0, 1'b1, 5'd1, '{7'h00, 1'b1}},
        '{8'h1F, 1'b0, 1'b1, 5'd0, '{7'h00, 1'b0}},
        '{8'h42, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h43, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h00, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h80, 1'b0, 1'b1, 5'd0, '{7'h00, 1'b0}},
        '{8'h44, 1'b0, 1'b0, 5'd0, '{7'h00, 1'b0}},
        '{8'h00, 1'b1, 1'b1, 5'd0, '{7'h00, 1'b0}},
        '{8'h45, 1'b1, 1'b1, 5'd0, '{7'h00, 1'b0}},
        '{8'h00, 1'b1, 1'b1, 5'd0, '{7'h00, 1'b0}}
    };

    utf16le_printable_run_extractor #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void owe_text(input logic [6:0] ch, input logic last);
        u16run_pkg::t_out_item r;
        r.text_char = ch;
        r.run_end   = last;
        expected_text.push_back(r);
        step_results++;
    endfunction

    function automatic void close_run();
        if (pair_cnt > min_pairs)
            owe_text('0, 1'b1);
        pair_cnt  = '0;
        cand_open = 1'b0;
    endfunction

    function automatic void add_pair();
        int i;
        if (pair_cnt != u16run_pkg::COUNT_MAX)
            pair_cnt++;
        if (int'(pair_cnt) <= HOLD_DEPTH)
            held_chars[int'(pair_cnt) - 1] = cand_char;
        if (int'(pair_cnt) == int'(min_pairs) + 1) begin
            for (i = 0; i + 1 < int'(pair_cnt); i++) begin
                if (i < HOLD_DEPTH)
                    owe_text(held_chars[i], 1'b0);
            end
            owe_text(cand_char, 1'b0);
        end else if (int'(pair_cnt) > int'(min_pairs) + 1) begin
            owe_text(cand_char, 1'b0);
        end
        cand_open = 1'b0;
    endfunction

    function automatic void predict_text(input u16run_pkg::t_in_item req);
        logic printable;
        printable    = (req.data_byte >= u16run_pkg::PRINT_LO) &&
                       (req.data_byte <= u16run_pkg::PRINT_HI);
        step_results = 0;
        if (cand_open) begin
            if (req.data_byte == u16run_pkg::BYTE_ZERO) begin
                add_pair();
            end else begin
                // candidate dropped, the byte itself may start the next one
                close_run();
                if (printable) begin
                    cand_char = req.data_byte[6:0];
                    cand_open = 1'b1;
                end
            end
        end else if (printable) begin
            cand_char = req.data_byte[6:0];
            cand_open = 1'b1;
        end else begin
            close_run();
        end
        if (req.is_final) begin
            close_run();
            cand_char = '0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        u16run_pkg::t_in_item req;
        req.data_byte = b;
        req.is_final  = fin;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        predict_text(req);
    endtask

    task automatic send_run(input int len);
        int         k;
        t_run_close how;
        logic [7:0] b;
        how = t_run_close'($urandom_range(0, 4));
        for (k = 0; k < len; k++) begin
            b = 8'($urandom_range(u16run_pkg::PRINT_LO, u16run_pkg::PRINT_HI));
            send_byte(b, 1'b0);
            send_byte(u16run_pkg::BYTE_ZERO, (k + 1 == len) && (how == END_FINAL_PAIR));
        end
        case (how)
            END_NONPRINT: begin
                b = $urandom_range(0, 1) ? 8'($urandom_range(1, 8'h1F))
                                         : 8'($urandom_range(8'h7F, 8'hFF));
                send_byte(b, $urandom_range(0, 7) == 0);
            end
            END_PRINTABLE: begin
                b = 8'($urandom_range(u16run_pkg::PRINT_LO, u16run_pkg::PRINT_HI));
                send_byte(b, 1'b0);
            end
            END_FINAL_PAIR: begin
                if (len == 0)
                    send_byte(u16run_pkg::BYTE_ZERO, 1'b1);
            end
            END_LONE: begin
                b = 8'($urandom_range(u16run_pkg::PRINT_LO, u16run_pkg::PRINT_HI));
                send_byte(b, 1'b1);
            end
            default: begin
            end
        endcase
    endtask

    // register written only once the block has drained
    task automatic write_min_chars(input logic [3:0] v);
        i_in_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        min_pairs = v;
        i_cfg_we <= 1'b0;
    endtask

    // output back-pressure in bursts; long open windows give clean stretches
    initial begin : sink_pace
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : out_check
        u16run_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_text.size() == 0) begin
                report_mismatch($sformatf("unexpected result char=%h end=%b",
                                          o_out_data.text_char, o_out_data.run_end));
            end else begin
                want = expected_text.pop_front();
                if (o_out_data.text_char !== want.text_char)
                    report_mismatch($sformatf("text_char got %h want %h",
                                              o_out_data.text_char, want.text_char));
                if (o_out_data.run_end !== want.run_end)
                    report_mismatch($sformatf("run_end got %b want %b",
                                              o_out_data.run_end, want.run_end));
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no request moved for %0d cycles",
                     $realtime, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int         r;
        int         ph;
        int         sent;
        int         runs;
        int         len;
        logic [3:0] setting;
        logic [7:0] b;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < N_ROWS; r++) begin
            send_byte(directed_rows[r].data_byte, directed_rows[r].is_final);
            if (directed_rows[r].typed) begin
                if (step_results != int'(directed_rows[r].n_out))
                    report_mismatch($sformatf("row %0d: predicted %0d results, table %0d",
                                              r, step_results, directed_rows[r].n_out));
                else if (step_results > 0 && expected_text[$] != directed_rows[r].last_out)
                    report_mismatch($sformatf("row %0d: last result disagrees with table", r));
            end
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       setting = 4'd0;
                1:       setting = 4'd15;
                4:       setting = 4'd1;
                default: setting = 4'($urandom_range(0, 15));
            endcase
            write_min_chars(setting);
            calm = (ph == N_PHASES - 1);
            sent = 0;
            runs = 0;
            while (sent < PHASE_BYTES) begin
                if ($urandom_range(0, 4) == 0) begin
                    b = 8'($urandom_range(0, 255));
                    send_byte(b, $urandom_range(0, 7) == 0);
                    sent++;
                end else begin
                    // one run past the count saturation while the threshold is highest
                    if (ph == 1 && runs == 0) begin
                        len = 33;
                    end else begin
                        case ($urandom_range(0, 19))
                            0:          len = $urandom_range(31, 35);
                            1, 2, 3, 4: len = int'(min_pairs) + 1;
                            5, 6:       len = int'(min_pairs);
                            default:    len = $urandom_range(0, int'(min_pairs) + 4);
                        endcase
                    end
                    send_run(len);
                    sent += 2 * len + 1;
                    runs++;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (expected_text.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_text.size()));
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/u16run_pkg.sv
hw/rtl/utf16le_printable_run_extractor.sv
hw/rtl/u16run_chk.sv
dv/tb_utf16le_printable_run_extractor.sv
